// File: rtl/core/cfd_pkg.sv
package cfd_pkg;

  // Largest payload the block ever accepts, whatever length_limit says
  localparam int unsigned MAX_PAYLOAD = 96;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [7:0] VERSION_RST     = 8'h01;
  localparam logic [6:0] LEN_LIMIT_RST   = 7'd96;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_LEN_LIMIT   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_VER_ERR   = 2'd2,
    ST_ABANDONED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] expected_version;
    logic [6:0] length_limit;
  } cfd_cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] message_id;
    logic [7:0] sequence_no;
    logic [6:0] payload_length;
    status_t    status;
  } cfd_result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/cfd_parser.sv
module cfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  cfd_pkg::cfd_cfg_t    cfg,
  output logic                 res_valid,
  output cfd_pkg::cfd_result_t res
);
  import cfd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT0 = 4'd0,
    PH_HUNT1 = 4'd1,
    PH_VER   = 4'd2,
    PH_LENL  = 4'd3,
    PH_LENH  = 4'd4,
    PH_ID    = 4'd5,
    PH_SEQ   = 4'd6,
    PH_PAY   = 4'd7,
    PH_CRCL  = 4'd8,
    PH_CRCH  = 4'd9
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [6:0]  length_r, length_nxt;
  logic [7:0]  msg_id_r, msg_id_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [15:0] full_len;
  logic [15:0] limit;
  logic [6:0]  count_inc;

  always_comb begin
    crc_upd   = crc16_byte(crc_r, rx_byte);
    full_len  = {rx_byte, len_lo_r};
    limit     = (16'(cfg.length_limit) < 16'(MAX_PAYLOAD)) ? 16'(cfg.length_limit)
                                                           : 16'(MAX_PAYLOAD);
    count_inc = count_r + 7'd1;

    phase_nxt   = phase_r;
    version_nxt = version_r;
    len_lo_nxt  = len_lo_r;
    length_nxt  = length_r;
    msg_id_nxt  = msg_id_r;
    seq_nxt     = seq_r;
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;

    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.data_byte      = 8'h00;
    res.byte_index     = 7'd0;
    res.message_id     = msg_id_r;
    res.sequence_no    = seq_r;
    res.payload_length = length_r;
    res.status         = ST_OK;

    unique case (phase_r)
      PH_HUNT0: begin
        if (rx_byte == cfg.sync_first) phase_nxt = PH_HUNT1;
      end
      PH_HUNT1: begin
        // a bad second byte is not retried as a first byte
        if (rx_byte == cfg.sync_second) begin
          phase_nxt = PH_VER;
          crc_nxt   = CRC_INIT;
        end else begin
          phase_nxt = PH_HUNT0;
        end
      end
      PH_VER: begin
        version_nxt = rx_byte;
        crc_nxt     = crc_upd;
        phase_nxt   = PH_LENL;
      end
      PH_LENL: begin
        len_lo_nxt = rx_byte;
        crc_nxt    = crc_upd;
        phase_nxt  = PH_LENH;
      end
      PH_LENH: begin
        crc_nxt    = crc_upd;
        length_nxt = full_len[6:0];
        if (full_len > limit) begin
          res_valid          = 1'b1;
          res.kind           = KIND_VERDICT;
          res.message_id     = 8'h00;
          res.sequence_no    = 8'h00;
          res.payload_length = (full_len > 16'd127) ? 7'd127 : full_len[6:0];
          res.status         = ST_ABANDONED;
          phase_nxt          = PH_HUNT0;
        end else begin
          phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        msg_id_nxt = rx_byte;
        crc_nxt    = crc_upd;
        phase_nxt  = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        count_nxt = 7'd0;
        phase_nxt = (length_r == 7'd0) ? PH_CRCL : PH_PAY;
      end
      PH_PAY: begin
        crc_nxt        = crc_upd;
        res_valid      = 1'b1;
        res.data_byte  = rx_byte;
        res.byte_index = count_r;
        count_nxt      = count_inc;
        if (count_inc >= length_r) phase_nxt = PH_CRCL;
      end
      PH_CRCL: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = PH_CRCH;
      end
      PH_CRCH: begin
        res_valid = 1'b1;
        res.kind  = KIND_VERDICT;
        // CRC mismatch wins over a wrong version
        priority if ({rx_byte, crc_lo_r} != crc_r) res.status = ST_CRC_ERR;
        else if (version_r != cfg.expected_version) res.status = ST_VER_ERR;
        else res.status = ST_OK;
        phase_nxt = PH_HUNT0;
      end
      default: begin
        phase_nxt = PH_HUNT0;
      end
    endcase

    if (!step) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
    if (step) begin
      version_r <= version_nxt;
      len_lo_r  <= len_lo_nxt;
      length_r  <= length_nxt;
      msg_id_r  <= msg_id_nxt;
      seq_r     <= seq_nxt;
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

endmodule

// File: rtl/core/crc_checked_frame_deframer.sv
// Byte-stream deframer: hunts for a two-byte sync header, parses version,
// little-endian length, message id and sequence number, passes each payload
// byte on with its index and ends every frame with one verdict item (ok, CRC
// mismatch, wrong version, or abandoned for a length over the limit). The CRC
// is CRC-16/CCITT-FALSE over version..payload, checked against the
// little-endian CRC that trails the frame. One byte is accepted every clock
// while in_stall is low, in_stall rising when out_stall holds a result; each
// byte passes through the input register, then the byte-wide CRC update and
// phase step, then the output register. Configuration is written through
// cfg_* by the user while no frame is in flight, not enforced by the block.
module crc_checked_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [6:0] out_byte_index,
  output logic [7:0] out_message_id,
  output logic [7:0] out_sequence_no,
  output logic [6:0] out_payload_length,
  output logic [1:0] out_status
);
  import cfd_pkg::*;

  cfd_cfg_t    cfg_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  cfd_result_t out_r;
  logic        out_free;
  logic        step;
  logic        res_valid;
  cfd_result_t res;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first       <= SYNC_FIRST_RST;
      cfg_r.sync_second      <= SYNC_SECOND_RST;
      cfg_r.expected_version <= VERSION_RST;
      cfg_r.length_limit     <= LEN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_FIRST:  cfg_r.sync_first       <= cfg_data;
        CFG_SYNC_SECOND: cfg_r.sync_second      <= cfg_data;
        CFG_VERSION:     cfg_r.expected_version <= cfg_data;
        CFG_LEN_LIMIT:   cfg_r.length_limit     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall) s1_byte_r <= in_rx_byte;
  end

  cfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
    if (out_free && res_valid) out_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_data_byte      = out_r.data_byte;
  assign out_byte_index     = out_r.byte_index;
  assign out_message_id     = out_r.message_id;
  assign out_sequence_no    = out_r.sequence_no;
  assign out_payload_length = out_r.payload_length;
  assign out_status         = out_r.status;

endmodule
